/* design/rcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rcw_pkg;

    // linked event store
    localparam int LINKED_MAX    = 8;
    localparam int IDX_W         = (LINKED_MAX > 1) ? $clog2(LINKED_MAX) : 1;
    localparam int COUNT_W       = 4;
    localparam int EVENT_W       = 64;
    localparam int TIME_W        = 32;
    localparam int POST_ROLL_W   = 12;
    localparam int MS_PER_SECOND = 1000;

    // request codes
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_EXTEND = 2'd2;
    localparam logic [1:0] REQ_STOP   = 2'd3;

    // event memory write and read request
    typedef struct packed {
        logic                      we;
        logic [IDX_W-1:0]          waddr;
        logic signed [EVENT_W-1:0] wdata;
        logic                      re;
        logic [IDX_W-1:0]          raddr;
    } ram_req_t;

endpackage

`default_nettype wire

/* design/retriggerable_capture_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// one request at a time: accept, decide, then a scan of the stored events for a duplicate
// (start or extend while open), then the output register.
// a stop while open streams one result per cycle from the event memory read port while the result side is ready.
// reset (synchronous, aresetn low): window idle, count zero, post-roll 3 s;
// the event memory is not cleared and is only read below the stored count.

module retriggerable_capture_window (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_req_type,
    input  wire logic signed [rcw_pkg::EVENT_W-1:0] s_event_id,
    input  wire logic [rcw_pkg::TIME_W-1:0]         s_now_ms,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_recording,
    output logic                                    m_clip_started,
    output logic                                    m_window_extended,
    output logic                                    m_clip_finished,
    output logic                                    m_event_added,
    output logic                                    m_list_full,
    output logic [rcw_pkg::COUNT_W-1:0]             m_link_total,
    output logic [rcw_pkg::TIME_W-1:0]              m_clip_len_ms,
    output logic                                    m_stop_refused,
    output logic signed [rcw_pkg::EVENT_W-1:0]      m_linked_event,
    output logic                                    m_last_result
);
    import rcw_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_RECORDING,
        MODE_EXTENDING
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT,
        ST_READ
    } state_t;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(LINKED_MAX);
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // configuration register
    logic [POST_ROLL_W-1:0]    post_roll_reg;

    // window state
    state_t                    state_reg;
    mode_t                     mode_reg;
    logic [TIME_W-1:0]         start_reg;
    logic [TIME_W-1:0]         deadline_reg;
    logic [COUNT_W-1:0]        count_reg;

    // latched request
    logic [1:0]                req_reg;
    logic signed [EVENT_W-1:0] ev_reg;
    logic [TIME_W-1:0]         now_reg;
    logic [TIME_W-1:0]         end_reg;

    // scan and readout
    logic [IDX_W-1:0]          idx_reg;
    logic                      known_reg;

    // pending result
    logic                      res_recording_reg;
    logic                      res_started_reg;
    logic                      res_extended_reg;
    logic                      res_finished_reg;
    logic                      res_added_reg;
    logic                      res_full_reg;
    logic                      res_refused_reg;
    logic [TIME_W-1:0]         res_duration_reg;

    // output register
    logic                      m_valid_reg;
    logic                      m_recording_reg;
    logic                      m_started_reg;
    logic                      m_extended_reg;
    logic                      m_finished_reg;
    logic                      m_added_reg;
    logic                      m_full_reg;
    logic [COUNT_W-1:0]        m_count_reg;
    logic [TIME_W-1:0]         m_duration_reg;
    logic                      m_refused_reg;
    logic signed [EVENT_W-1:0] m_event_reg;
    logic                      m_last_reg;

    ram_req_t                  ram_req;
    logic signed [EVENT_W-1:0] ram_rdata;

    logic                      win_open;
    logic                      is_trigger;
    logic                      idx_last;
    logic                      known_now;
    logic                      out_free;
    logic                      out_load;
    logic                      in_take;
    logic [TIME_W-1:0]         end_calc;

    rcw_event_ram u_event_ram (
        .aclk      (aclk),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // apb register port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-POST_ROLL_W){1'b0}}, post_roll_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_roll_reg <= POST_ROLL_W'(3);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            post_roll_reg <= pwdata[POST_ROLL_W-1:0];
        end
    end

    // shared decode
    assign win_open   = (mode_reg != MODE_IDLE);
    assign is_trigger = (req_reg == REQ_START) || (req_reg == REQ_EXTEND);
    assign idx_last   = ((COUNT_W'(idx_reg) + COUNT_ONE) == count_reg);
    assign known_now  = known_reg || (ram_rdata == ev_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = out_free && ((state_reg == ST_EMIT) || (state_reg == ST_READ));
    assign in_take    = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign end_calc   = s_now_ms
                      + TIME_W'(post_roll_reg * (POST_ROLL_W + 10)'(MS_PER_SECOND));

    // event memory requests
    always_comb begin
        ram_req       = '0;
        ram_req.wdata = ev_reg;
        ram_req.waddr = count_reg[IDX_W-1:0];
        case (state_reg)
            ST_DECIDE: begin
                if (req_reg == REQ_STOP) begin
                    ram_req.re = win_open && (count_reg != '0);
                end else if (req_reg == REQ_START && !win_open) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = '0;
                end else if (is_trigger && win_open && count_reg < COUNT_MAX) begin
                    ram_req.we = (count_reg == '0);
                    ram_req.re = (count_reg != '0);
                end
            end
            ST_SCAN: begin
                if (!idx_last) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg + IDX_W'(1);
                end else begin
                    ram_req.we = !known_now;
                end
            end
            ST_READ: begin
                if (out_free && !idx_last) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer, window state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_IDLE;
            start_reg    <= '0;
            deadline_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_take) begin
                        req_reg   <= s_req_type;
                        ev_reg    <= s_event_id;
                        now_reg   <= s_now_ms;
                        end_reg   <= end_calc;
                        state_reg <= ST_DECIDE;
                    end
                end

                ST_DECIDE: begin
                    res_recording_reg <= 1'b0;
                    res_started_reg   <= 1'b0;
                    res_extended_reg  <= 1'b0;
                    res_finished_reg  <= 1'b0;
                    res_added_reg     <= 1'b0;
                    res_full_reg      <= 1'b0;
                    res_refused_reg   <= 1'b0;
                    res_duration_reg  <= '0;
                    idx_reg           <= '0;
                    known_reg         <= 1'b0;
                    state_reg         <= ST_EMIT;
                    case (req_reg)
                        REQ_STOP: begin
                            if (!win_open) begin
                                res_refused_reg <= 1'b1;
                            end else begin
                                mode_reg         <= MODE_IDLE;
                                res_finished_reg <= 1'b1;
                                res_duration_reg <= now_reg - start_reg;
                                if (count_reg != '0) begin
                                    state_reg <= ST_READ;
                                end
                            end
                        end
                        REQ_START, REQ_EXTEND: begin
                            if (!win_open) begin
                                if (req_reg == REQ_START) begin
                                    count_reg         <= COUNT_ONE;
                                    mode_reg          <= MODE_RECORDING;
                                    start_reg         <= now_reg;
                                    deadline_reg      <= end_reg;
                                    res_started_reg   <= 1'b1;
                                    res_added_reg     <= 1'b1;
                                    res_recording_reg <= 1'b1;
                                end
                            end else begin
                                res_recording_reg <= 1'b1;
                                // plain compare, not wrap safe
                                if (end_reg > deadline_reg) begin
                                    deadline_reg     <= end_reg;
                                    mode_reg         <= MODE_EXTENDING;
                                    res_extended_reg <= 1'b1;
                                end
                                if (count_reg >= COUNT_MAX) begin
                                    res_full_reg <= 1'b1;
                                end else if (count_reg == '0) begin
                                    count_reg     <= COUNT_ONE;
                                    res_added_reg <= 1'b1;
                                end else begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                        end
                        REQ_TICK: begin
                            if (win_open) begin
                                if ((now_reg - start_reg) >= (deadline_reg - start_reg)) begin
                                    mode_reg         <= MODE_IDLE;
                                    res_finished_reg <= 1'b1;
                                    res_duration_reg <= now_reg - start_reg;
                                end else begin
                                    res_recording_reg <= 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // duplicate scan, one stored event per cycle
                ST_SCAN: begin
                    if (idx_last) begin
                        if (!known_now) begin
                            count_reg     <= count_reg + COUNT_ONE;
                            res_added_reg <= 1'b1;
                        end
                        state_reg <= ST_EMIT;
                    end else begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        known_reg <= known_now;
                    end
                end

                ST_EMIT: begin
                    if (out_free) begin
                        m_recording_reg <= res_recording_reg;
                        m_started_reg   <= res_started_reg;
                        m_extended_reg  <= res_extended_reg;
                        m_finished_reg  <= res_finished_reg;
                        m_added_reg     <= res_added_reg;
                        m_full_reg      <= res_full_reg;
                        m_count_reg     <= count_reg;
                        m_duration_reg  <= res_duration_reg;
                        m_refused_reg   <= res_refused_reg;
                        m_event_reg     <= '0;
                        m_last_reg      <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end

                // stop readout, one linked event per result
                ST_READ: begin
                    if (out_free) begin
                        m_recording_reg <= 1'b0;
                        m_started_reg   <= 1'b0;
                        m_extended_reg  <= 1'b0;
                        m_finished_reg  <= 1'b1;
                        m_added_reg     <= 1'b0;
                        m_full_reg      <= 1'b0;
                        m_count_reg     <= count_reg;
                        m_duration_reg  <= res_duration_reg;
                        m_refused_reg   <= 1'b0;
                        m_event_reg     <= ram_rdata;
                        m_last_reg      <= idx_last;
                        if (idx_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_recording       = m_recording_reg;
    assign m_clip_started    = m_started_reg;
    assign m_window_extended = m_extended_reg;
    assign m_clip_finished   = m_finished_reg;
    assign m_event_added     = m_added_reg;
    assign m_list_full       = m_full_reg;
    assign m_link_total      = m_count_reg;
    assign m_clip_len_ms     = m_duration_reg;
    assign m_stop_refused    = m_refused_reg;
    assign m_linked_event    = m_event_reg;
    assign m_last_result     = m_last_reg;

    // stored count never passes the list size
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("linked count above list size");

    // an open window always holds at least its opening event
    assert property (@(posedge aclk) disable iff (!aresetn)
        win_open |-> (count_reg != '0))
        else $error("open window with empty event list");

    // only a stop readout produces results that are not the last
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> m_finished_reg)
        else $error("non-final result outside stop readout");

    // a request is processed before the next one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> !s_ready)
        else $error("request taken while one is in progress");

endmodule

`default_nettype wire

/* design/rcw_event_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rcw_event_ram (
    input  wire logic                              aclk,
    input  wire rcw_pkg::ram_req_t                 ram_req,
    output logic signed [rcw_pkg::EVENT_W-1:0]     ram_rdata
);
    import rcw_pkg::*;

    logic signed [EVENT_W-1:0] mem [LINKED_MAX];
    logic signed [EVENT_W-1:0] rdata_reg;

    // one write port, one registered read port; read data holds until next read
    always_ff @(posedge aclk) begin
        if (ram_req.we) begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        if (ram_req.re) begin
            rdata_reg <= mem[ram_req.raddr];
        end
    end

    assign ram_rdata = rdata_reg;

endmodule

`default_nettype wire

/* tb/capture_window_checker.sv */
`timescale 1ns / 1ps

module capture_window_checker #(
    parameter logic [2:0] POST_ROLL_ADDR = 3'd0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         pready,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [rcw_pkg::EVENT_W-1:0]  s_event_id,
    input  logic [rcw_pkg::TIME_W-1:0]   s_now_ms,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         m_recording,
    input  logic                         m_clip_started,
    input  logic                         m_window_extended,
    input  logic                         m_clip_finished,
    input  logic                         m_event_added,
    input  logic                         m_list_full,
    input  logic [rcw_pkg::COUNT_W-1:0]  m_link_total,
    input  logic [rcw_pkg::TIME_W-1:0]   m_clip_len_ms,
    input  logic                         m_stop_refused,
    input  logic [rcw_pkg::EVENT_W-1:0]  m_linked_event,
    input  logic                         m_last_result,
    output int                           fail_count,
    output int                           outstanding
);
    import rcw_pkg::*;

    localparam logic [POST_ROLL_W-1:0] POST_ROLL_RESET = 12'd3;

    typedef enum logic [1:0] {
        WIN_IDLE      = 2'd0,
        WIN_RECORDING = 2'd1,
        WIN_EXTENDING = 2'd2
    } win_mode_t;

    typedef struct packed {
        logic                recording;
        logic                clip_started;
        logic                window_extended;
        logic                clip_finished;
        logic                event_added;
        logic                list_full;
        logic [COUNT_W-1:0]  link_total;
        logic [TIME_W-1:0]   clip_len_ms;
        logic                stop_refused;
        logic [EVENT_W-1:0]  linked_event;
        logic                last_result;
    } capture_result_t;

    // shadow of the window state
    win_mode_t              win_mode;
    logic [TIME_W-1:0]      win_start;
    logic [TIME_W-1:0]      win_deadline;
    logic [POST_ROLL_W-1:0] post_roll_s;
    logic [EVENT_W-1:0]     linked_ids [LINKED_MAX];
    int unsigned            linked_n;
    capture_result_t        expected_q [$];
    int                     mismatches = 0;
    int                     queued = 0;

    assign fail_count  = mismatches;
    assign outstanding = queued;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic logic [TIME_W-1:0] deadline_after(input logic [TIME_W-1:0] now);
        return now + TIME_W'(post_roll_s) * TIME_W'(MS_PER_SECOND);
    endfunction

    // work out the results of one accepted request
    task automatic predict_request(input logic [1:0] req, input logic [EVENT_W-1:0] ev,
                                   input logic [TIME_W-1:0] now);
        capture_result_t  r;
        logic             was_open;
        logic             known;
        logic [TIME_W-1:0] new_end;
        r        = '0;
        was_open = (win_mode != WIN_IDLE);
        if (req == REQ_STOP) begin
            r.link_total = COUNT_W'(linked_n);
            if (!was_open) begin
                r.stop_refused = 1'b1;
                r.last_result  = 1'b1;
                expected_q.push_back(r);
            end else begin
                // close and read out the linked events
                win_mode        = WIN_IDLE;
                r.clip_finished = 1'b1;
                r.clip_len_ms   = now - win_start;
                if (linked_n == 0) begin
                    r.last_result = 1'b1;
                    expected_q.push_back(r);
                end else begin
                    for (int k = 0; k < linked_n; k++) begin
                        r.linked_event = linked_ids[k];
                        r.last_result  = (k == linked_n - 1);
                        expected_q.push_back(r);
                    end
                end
            end
        end else begin
            if (req == REQ_START && !was_open) begin
                // fresh window
                linked_ids[0]  = ev;
                linked_n       = 1;
                win_mode       = WIN_RECORDING;
                win_start      = now;
                win_deadline   = deadline_after(now);
                r.clip_started = 1'b1;
                r.event_added  = 1'b1;
            end else if ((req == REQ_START || req == REQ_EXTEND) && was_open) begin
                // plain compare, not wrap-safe
                new_end = deadline_after(now);
                if (new_end > win_deadline) begin
                    win_deadline      = new_end;
                    win_mode          = WIN_EXTENDING;
                    r.window_extended = 1'b1;
                end
                // full test before duplicate test
                if (linked_n >= LINKED_MAX) begin
                    r.list_full = 1'b1;
                end else begin
                    known = 1'b0;
                    for (int k = 0; k < linked_n; k++)
                        if (linked_ids[k] == ev)
                            known = 1'b1;
                    if (!known) begin
                        linked_ids[linked_n] = ev;
                        linked_n++;
                        r.event_added = 1'b1;
                    end
                end
            end else if (req == REQ_TICK && was_open) begin
                // wrap-safe elapsed against window length
                if ((now - win_start) >= (win_deadline - win_start)) begin
                    win_mode        = WIN_IDLE;
                    r.clip_finished = 1'b1;
                    r.clip_len_ms   = now - win_start;
                end
            end
            r.recording   = (win_mode != WIN_IDLE);
            r.link_total  = COUNT_W'(linked_n);
            r.last_result = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    // register writes, requests in, results out
    always @(posedge aclk) begin
        capture_result_t got;
        capture_result_t want;
        if (!aresetn) begin
            win_mode     = WIN_IDLE;
            win_start    = '0;
            win_deadline = '0;
            post_roll_s  = POST_ROLL_RESET;
            linked_n     = 0;
            foreach (linked_ids[i])
                linked_ids[i] = '0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == POST_ROLL_ADDR)
                post_roll_s = pwdata[POST_ROLL_W-1:0];
            if (s_valid && s_ready)
                predict_request(s_req_type, s_event_id, s_now_ms);
            if (m_valid && m_ready) begin
                got = {m_recording, m_clip_started, m_window_extended, m_clip_finished,
                       m_event_added, m_list_full, m_link_total, m_clip_len_ms,
                       m_stop_refused, m_linked_event, m_last_result};
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    check_field("recording", 64'(got.recording), 64'(want.recording));
                    check_field("clip_started", 64'(got.clip_started),
                                64'(want.clip_started));
                    check_field("window_extended", 64'(got.window_extended),
                                64'(want.window_extended));
                    check_field("clip_finished", 64'(got.clip_finished),
                                64'(want.clip_finished));
                    check_field("event_added", 64'(got.event_added), 64'(want.event_added));
                    check_field("list_full", 64'(got.list_full), 64'(want.list_full));
                    check_field("link_total", 64'(got.link_total), 64'(want.link_total));
                    check_field("clip_len_ms", 64'(got.clip_len_ms), 64'(want.clip_len_ms));
                    check_field("stop_refused", 64'(got.stop_refused),
                                64'(want.stop_refused));
                    check_field("linked_event", got.linked_event, want.linked_event);
                    check_field("last_result", 64'(got.last_result), 64'(want.last_result));
                end
            end
        end
        queued <= expected_q.size();
    end

endmodule

/* tb/tb_retriggerable_capture_window.sv */
`timescale 1ns / 1ps

module tb_retriggerable_capture_window;
    import rcw_pkg::*;

    localparam logic [2:0] POST_ROLL_ADDR = 3'd0;
    localparam int PHASE_ITEMS   = 37;
    localparam int LONG_HOLD     = 200;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 24;

    localparam logic [EVENT_W-1:0] ID_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [EVENT_W-1:0] ID_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [EVENT_W-1:0] ID_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_req_type;
    logic [EVENT_W-1:0]   s_event_id;
    logic [TIME_W-1:0]    s_now_ms;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_recording;
    logic                 m_clip_started;
    logic                 m_window_extended;
    logic                 m_clip_finished;
    logic                 m_event_added;
    logic                 m_list_full;
    logic [COUNT_W-1:0]   m_link_total;
    logic [TIME_W-1:0]    m_clip_len_ms;
    logic                 m_stop_refused;
    logic [EVENT_W-1:0]   m_linked_event;
    logic                 m_last_result;
    int                   fail_count;
    int                   outstanding;

    bit                   calm = 1'b0;
    bit                   hold_results = 1'b0;
    logic [TIME_W-1:0]    clock_ms;

    retriggerable_capture_window u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_event_id        (s_event_id),
        .s_now_ms          (s_now_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_recording       (m_recording),
        .m_clip_started    (m_clip_started),
        .m_window_extended (m_window_extended),
        .m_clip_finished   (m_clip_finished),
        .m_event_added     (m_event_added),
        .m_list_full       (m_list_full),
        .m_link_total      (m_link_total),
        .m_clip_len_ms     (m_clip_len_ms),
        .m_stop_refused    (m_stop_refused),
        .m_linked_event    (m_linked_event),
        .m_last_result     (m_last_result)
    );

    capture_window_checker #(
        .POST_ROLL_ADDR (POST_ROLL_ADDR)
    ) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_event_id        (s_event_id),
        .s_now_ms          (s_now_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_recording       (m_recording),
        .m_clip_started    (m_clip_started),
        .m_window_extended (m_window_extended),
        .m_clip_finished   (m_clip_finished),
        .m_event_added     (m_event_added),
        .m_list_full       (m_list_full),
        .m_link_total      (m_link_total),
        .m_clip_len_ms     (m_clip_len_ms),
        .m_stop_refused    (m_stop_refused),
        .m_linked_event    (m_linked_event),
        .m_last_result     (m_last_result),
        .fail_count        (fail_count),
        .outstanding       (outstanding)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // offer one request, holding it until taken
    task automatic send_request(input logic [1:0] req, input logic [EVENT_W-1:0] ev,
                                input logic [TIME_W-1:0] now);
        if (!calm && !hold_results && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_event_id <= ev;
        s_now_ms   <= now;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait for every expected result
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // setup then access cycle, block idle
    task automatic write_post_roll(input logic [POST_ROLL_W-1:0] seconds);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= POST_ROLL_ADDR;
        pwdata  <= 32'(seconds);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one post-roll setting: mostly capture sessions, some noise
    task automatic run_phase(input logic [POST_ROLL_W-1:0] seconds, input int quota,
                             input bit hold_first);
        logic [EVENT_W-1:0] pool [10];
        int                 sent;
        int                 steps;
        int                 pick;
        int unsigned        span;
        drain_results();
        write_post_roll(seconds);
        if (hold_first)
            hold_results = 1'b1;
        clock_ms = $urandom;
        span     = int'(seconds) * 1000 + 1500;
        sent     = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 4) == 0) begin
                // noise: any request at any time
                send_request(2'($urandom), {$urandom, $urandom}, $urandom);
                sent++;
            end else begin
                // a session over a small id pool so duplicates and full lists occur
                foreach (pool[i])
                    pool[i] = {$urandom, $urandom};
                send_request(REQ_START, pool[$urandom_range(0, 9)], clock_ms);
                sent++;
                steps = $urandom_range(2, 12);
                repeat (steps) begin
                    if ($urandom_range(0, 5) == 0)
                        clock_ms += $urandom_range(0, span);
                    else
                        clock_ms += $urandom_range(0, 800);
                    pick = $urandom_range(0, 19);
                    if (pick < 10)
                        send_request(REQ_EXTEND, pool[$urandom_range(0, 9)], clock_ms);
                    else if (pick < 13)
                        send_request(REQ_START, pool[$urandom_range(0, 9)], clock_ms);
                    else
                        send_request(REQ_TICK, {$urandom, $urandom}, clock_ms);
                    sent++;
                end
                if ($urandom_range(0, 1) == 0) begin
                    clock_ms += $urandom_range(0, 800);
                    send_request(REQ_STOP, {$urandom, $urandom}, clock_ms);
                    sent++;
                end
            end
        end
    endtask

    // result side: random stall bursts, one long hold on request
    initial begin : result_sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_results = 1'b0;
                m_ready <= 1'b1;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 1) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                run_left = $urandom_range(1, 30) - 1;
                m_ready <= 1'b1;
            end
        end
    end

    // end the run if nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        s_valid    <= 1'b0;
        s_req_type <= REQ_TICK;
        s_event_id <= '0;
        s_now_ms   <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= POST_ROLL_ADDR;
        pwdata     <= '0;
        aresetn    <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle window: tick, extend and stop do nothing
        send_request(REQ_TICK, 64'd0, 32'd5000);
        send_request(REQ_EXTEND, ID_ALL_ONES, 32'd5000);
        send_request(REQ_STOP, 64'd0, 32'd5000);
        // open, retrigger with a known id, equal deadline, earlier time
        send_request(REQ_START, ID_MIN, 32'd5000);
        send_request(REQ_START, ID_MIN, 32'd5010);
        send_request(REQ_EXTEND, ID_MAX, 32'd5010);
        send_request(REQ_EXTEND, 64'd0, 32'd5005);
        send_request(REQ_EXTEND, ID_ALL_ONES, 32'd5500);
        // fill the list, then a new and a known id while full
        send_request(REQ_EXTEND, 64'd1, 32'd5600);
        send_request(REQ_EXTEND, 64'd2, 32'd5700);
        send_request(REQ_EXTEND, 64'h0123_4567_89AB_CDEF, 32'd5800);
        send_request(REQ_EXTEND, 64'hAAAA_5555_AAAA_5555, 32'd5900);
        send_request(REQ_EXTEND, 64'd42, 32'd5950);
        send_request(REQ_EXTEND, ID_MIN, 32'd5960);
        // ticks short of the deadline, the window stays open
        send_request(REQ_TICK, 64'd0, 32'd6000);
        send_request(REQ_TICK, 64'd0, 32'd8500);
        // stop closes the window and reads out the linked events
        send_request(REQ_STOP, 64'd0, 32'd8600);
        // window across the time wrap, read out on stop
        send_request(REQ_START, 64'd7, 32'hFFFF_FC00);
        send_request(REQ_EXTEND, 64'd8, 32'hFFFF_FE00);
        send_request(REQ_EXTEND, 64'd9, 32'h0000_0100);
        send_request(REQ_TICK, 64'd0, 32'h0000_0200);
        send_request(REQ_STOP, 64'd0, 32'h0000_0300);
        // deadline below the wrap, later trigger wraps and fails the compare
        send_request(REQ_START, 64'd10, 32'hFFFF_F000);
        send_request(REQ_EXTEND, 64'd11, 32'hFFFF_FC00);
        send_request(REQ_STOP, 64'd0, 32'h0000_0010);

        run_phase(POST_ROLL_W'(0), PHASE_ITEMS, 1'b0);
        run_phase(POST_ROLL_W'(3600), PHASE_ITEMS, 1'b1);
        run_phase(POST_ROLL_W'(1), PHASE_ITEMS, 1'b0);
        run_phase(POST_ROLL_W'($urandom_range(0, 3600)), PHASE_ITEMS, 1'b0);
        run_phase(POST_ROLL_W'(2), PHASE_ITEMS, 1'b0);
        calm = 1'b1;
        run_phase(POST_ROLL_W'(3), PHASE_ITEMS, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
